// ===== src/cbm_pkg.sv =====
// Types and constants shared by the cartridge bank mapper.
package cbm_pkg;

   // Result target codes
   typedef enum logic [2:0] {
      TGT_OPEN   = 3'd0,
      TGT_ROM    = 3'd1,
      TGT_RAM_RD = 3'd2,
      TGT_RAM_WR = 3'd3,
      TGT_REG    = 3'd4
   } target_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_ROM_SIZE = 1'b0,
      CSR_RAM_SIZE = 1'b1
   } csr_index_type;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int ROM_ADDR_W = 21;
   localparam int RAM_ADDR_W = 15;
   localparam int REQ_DATA_W = 24;  // address + write_data
   localparam int RSP_DATA_W = 40;  // rom_address + ram_address, padded to bytes
   localparam int CSR_DATA_W = 3;

   localparam logic [2:0] ROM_CODE_1M = 3'd5;
   localparam logic [2:0] ROM_CODE_2M = 3'd6;
   localparam logic [1:0] RAM_CODE_NONE = 2'd0;
   localparam logic [1:0] RAM_CODE_2K   = 2'd1;
   localparam logic [1:0] RAM_CODE_32K  = 2'd3;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

// ===== src/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: bus access decode, bank registers and address mapping.
// The response is registered in the response slot from the accepted request transaction.
// Throughput: one transaction per cycle; the response register decouples the sides,
// so a new request is taken whenever the response slot is empty or being drained.
// Reset (synchronous, active high): bank registers, RAM enable, mode and size codes
// clear to zero and the response slot empties.
module cartridge_bank_mapper (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cbm_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] address, [23:16] write_data
   input  logic                           req_tuser,  // [0] kind: 0 read, 1 write
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cbm_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [20:0] rom_address, [35:21] ram_address, [39:36] zero
   output logic [2:0]                     rsp_tuser,  // [2:0] target
   // configuration write port
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [2:0] rom_size_ff;
   logic [1:0] ram_size_ff;

   // mapper state
   logic       ram_en_ff,    ram_en_in;
   logic [4:0] low_bank_ff,  low_bank_in;
   logic [1:0] high_bank_ff, high_bank_in;
   logic       mode_ff,      mode_in;

   // response slot
   logic                            rsp_valid_ff;
   cbm_pkg::target_type             target_ff,   target_in;
   logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_addr_ff, rom_addr_in;
   logic [cbm_pkg::RAM_ADDR_W-1:0]  ram_addr_ff, ram_addr_in;

   logic [cbm_pkg::ADDR_W-1:0] addr;
   logic [cbm_pkg::DATA_W-1:0] wdata;
   logic                       is_write;
   logic                       accept;

   logic [2:0] rom_code;     // size code with 7 folded onto 2MB
   logic [6:0] rom_mask;
   logic [6:0] lower_bank;
   logic [6:0] upper_bank;
   logic [4:0] low_nz;

   assign addr     = req_tdata[cbm_pkg::ADDR_W-1:0];
   assign wdata    = req_tdata[cbm_pkg::ADDR_W +: cbm_pkg::DATA_W];
   assign is_write = req_tuser;

   // Take a new transaction when the slot is free or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // ROM bank selection
   always_comb begin
      rom_code = (rom_size_ff > cbm_pkg::ROM_CODE_2M) ? cbm_pkg::ROM_CODE_2M : rom_size_ff;
      rom_mask = 7'((8'd2 << rom_code) - 8'd1);
      low_nz   = (low_bank_ff == 5'd0) ? 5'd1 : low_bank_ff;
      upper_bank = {high_bank_ff, low_nz} & rom_mask;
      // Mode 1 remaps the lower window on 1MB and 2MB parts only.
      if (!mode_ff || rom_code < cbm_pkg::ROM_CODE_1M) begin
         lower_bank = 7'd0;
      end else if (rom_code == cbm_pkg::ROM_CODE_1M) begin
         lower_bank = {1'b0, high_bank_ff[0], 5'd0};
      end else begin
         lower_bank = {high_bank_ff, 5'd0};
      end
   end

   // Access decode
   always_comb begin
      target_in    = cbm_pkg::TGT_OPEN;
      rom_addr_in  = '0;
      ram_addr_in  = '0;
      ram_en_in    = ram_en_ff;
      low_bank_in  = low_bank_ff;
      high_bank_in = high_bank_ff;
      mode_in      = mode_ff;

      if (addr[15:13] == 3'b101) begin
         // external RAM window 0xA000-0xBFFF
         target_in = is_write ? cbm_pkg::TGT_REG : cbm_pkg::TGT_OPEN;
         if (ram_size_ff != cbm_pkg::RAM_CODE_NONE && ram_en_ff) begin
            if (mode_ff && ram_size_ff == cbm_pkg::RAM_CODE_32K) begin
               ram_addr_in = {high_bank_ff, addr[12:0]};
               target_in   = is_write ? cbm_pkg::TGT_RAM_WR : cbm_pkg::TGT_RAM_RD;
            end else if (!(ram_size_ff == cbm_pkg::RAM_CODE_2K && (addr[12] || addr[11]))) begin
               // 2KB parts have nothing above 0xA7FF
               ram_addr_in = {2'b00, addr[12:0]};
               target_in   = is_write ? cbm_pkg::TGT_RAM_WR : cbm_pkg::TGT_RAM_RD;
            end
         end
      end else if (is_write) begin
         target_in = cbm_pkg::TGT_REG;
         case (addr[15:13])
            3'b000: ram_en_in    = (wdata[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            3'b001: low_bank_in  = wdata[4:0];
            3'b010: high_bank_in = wdata[1:0];
            3'b011: mode_in      = wdata[0];
            default: ;  // unmapped writes change nothing
         endcase
      end else if (!addr[15]) begin
         target_in = cbm_pkg::TGT_ROM;
         if (!addr[14]) begin
            rom_addr_in = {lower_bank, addr[13:0]};
         end else begin
            rom_addr_in = {upper_bank, addr[13:0]};
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff <= '0;
         ram_size_ff <= '0;
      end else if (csr_we) begin
         case (cbm_pkg::csr_index_type'(csr_index))
            cbm_pkg::CSR_ROM_SIZE: rom_size_ff <= csr_wdata;
            cbm_pkg::CSR_RAM_SIZE: ram_size_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // mapper state, updated only by accepted write transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_en_ff    <= 1'b0;
         low_bank_ff  <= '0;
         high_bank_ff <= '0;
         mode_ff      <= 1'b0;
      end else if (accept) begin
         ram_en_ff    <= ram_en_in;
         low_bank_ff  <= low_bank_in;
         high_bank_ff <= high_bank_in;
         mode_ff      <= mode_in;
      end
   end

   // response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff   <= target_in;
         rom_addr_ff <= rom_addr_in;
         ram_addr_ff <= ram_addr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = target_ff;
   assign rsp_tdata  = {4'd0, ram_addr_ff, rom_addr_ff};

endmodule
